FILE: rtl/core/msc_pkg.sv
// Shared types, constants and segment tables for the marching squares cell block.
package msc_pkg;

    localparam int GRID_SIZE   = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 8;
    localparam int IDX_BITS    = $clog2(GRID_SIZE);
    localparam int COORD_BITS  = IDX_BITS + FRAC_BITS;
    localparam int AW          = SAMPLE_BITS + 1;
    localparam int QW          = FRAC_BITS + 1;
    localparam int NUM_EDGES   = 4;
    localparam logic [IDX_BITS-1:0] IDX_MAX = IDX_BITS'(GRID_SIZE - 2);

    typedef enum logic [1:0] {
        EDGE_TOP    = 2'd0,
        EDGE_RIGHT  = 2'd1,
        EDGE_BOTTOM = 2'd2,
        EDGE_LEFT   = 2'd3
    } t_edge;

    typedef struct packed {
        logic [IDX_BITS-1:0]           cell_i;
        logic [IDX_BITS-1:0]           cell_j;
        logic signed [SAMPLE_BITS-1:0] value_i0_j1;
        logic signed [SAMPLE_BITS-1:0] value_i1_j1;
        logic signed [SAMPLE_BITS-1:0] value_i1_j0;
        logic signed [SAMPLE_BITS-1:0] value_i0_j0;
    } t_cell;

    typedef struct packed {
        logic [COORD_BITS-1:0] start_i;
        logic [COORD_BITS-1:0] start_j;
        logic [COORD_BITS-1:0] end_i;
        logic [COORD_BITS-1:0] end_j;
        logic                  last_segment;
    } t_seg;

    typedef struct packed {
        logic [IDX_BITS-1:0] base_i;
        logic [IDX_BITS-1:0] base_j;
        logic [3:0]          tab;
        logic                flip;
        logic [1:0]          nseg;
    } t_side;

    typedef struct packed {
        logic [QW-1:0] flo;
        logic [QW-1:0] cei;
    } t_quo;

    typedef struct packed {
        t_edge s0a;
        t_edge s0b;
        t_edge s1a;
        t_edge s1b;
    } t_segedges;

    // Number of segments a case produces
    function automatic logic [1:0] seg_count(input logic [3:0] cs);
        logic [1:0] n;
        case (cs)
            4'd0, 4'd15: n = 2'd0;
            4'd5, 4'd10: n = 2'd2;
            default:     n = 2'd1;
        endcase
        return n;
    endfunction

    // Crossed edges of each segment, start edge first
    function automatic t_segedges seg_edges(input logic [3:0] tab);
        t_segedges e;
        e = '{EDGE_TOP, EDGE_TOP, EDGE_TOP, EDGE_TOP};
        case (tab)
            4'd1:    e = '{EDGE_LEFT,   EDGE_BOTTOM, EDGE_TOP,    EDGE_TOP};
            4'd2:    e = '{EDGE_BOTTOM, EDGE_RIGHT,  EDGE_TOP,    EDGE_TOP};
            4'd3:    e = '{EDGE_LEFT,   EDGE_RIGHT,  EDGE_TOP,    EDGE_TOP};
            4'd4:    e = '{EDGE_TOP,    EDGE_RIGHT,  EDGE_TOP,    EDGE_TOP};
            4'd5:    e = '{EDGE_LEFT,   EDGE_TOP,    EDGE_RIGHT,  EDGE_BOTTOM};
            4'd6:    e = '{EDGE_BOTTOM, EDGE_TOP,    EDGE_TOP,    EDGE_TOP};
            4'd7:    e = '{EDGE_LEFT,   EDGE_TOP,    EDGE_TOP,    EDGE_TOP};
            4'd8:    e = '{EDGE_TOP,    EDGE_LEFT,   EDGE_TOP,    EDGE_TOP};
            4'd9:    e = '{EDGE_TOP,    EDGE_BOTTOM, EDGE_TOP,    EDGE_TOP};
            4'd10:   e = '{EDGE_TOP,    EDGE_RIGHT,  EDGE_BOTTOM, EDGE_LEFT};
            4'd11:   e = '{EDGE_TOP,    EDGE_RIGHT,  EDGE_TOP,    EDGE_TOP};
            4'd12:   e = '{EDGE_RIGHT,  EDGE_LEFT,   EDGE_TOP,    EDGE_TOP};
            4'd13:   e = '{EDGE_RIGHT,  EDGE_BOTTOM, EDGE_TOP,    EDGE_TOP};
            4'd14:   e = '{EDGE_BOTTOM, EDGE_LEFT,   EDGE_TOP,    EDGE_TOP};
            default: e = '{EDGE_TOP,    EDGE_TOP,    EDGE_TOP,    EDGE_TOP};
        endcase
        return e;
    endfunction

endpackage

FILE: rtl/core/msc_lane.sv
// One edge lane: pipelined restoring divider giving the floor and ceil crossing fraction.
module msc_lane
    import msc_pkg::*;
(
    input  logic          i_clk,
    input  logic [AW-1:0] i_un,
    input  logic [AW-1:0] i_ud,
    output t_quo          o_quo
);

    logic [AW-1:0] r_rem [QW];
    logic [AW-1:0] r_den [QW];
    logic [QW-1:0] r_quo [QW];
    logic          den_zero;

    // One quotient bit per stage
    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [AW:0]   rin;
        logic [AW-1:0] den;
        logic [QW-1:0] qin;
        logic          ge;
        logic [AW:0]   diff;

        if (k == 0) begin : g_first
            assign rin = {1'b0, i_un};
            assign den = i_ud;
            assign qin = '0;
        end else begin : g_next
            assign rin = {r_rem[k-1], 1'b0};
            assign den = r_den[k-1];
            assign qin = r_quo[k-1];
        end

        assign ge   = (rin >= {1'b0, den});
        assign diff = ge ? (rin - {1'b0, den}) : rin;

        // Advance the partial remainder
        always_ff @(posedge i_clk) begin
            r_rem[k] <= diff[AW-1:0];
            r_den[k] <= den;
            r_quo[k] <= {qin[QW-2:0], ge};
        end
    end

    // Drop the fraction on a flat edge, round up when a remainder is left
    assign den_zero  = (r_den[QW-1] == '0);
    assign o_quo.flo = den_zero ? '0 : r_quo[QW-1];
    assign o_quo.cei = den_zero ? '0
                     : r_quo[QW-1] + QW'(r_rem[QW-1] != '0);

endmodule

FILE: rtl/core/msc_merge.sv
// Merge stage: builds edge points from the lanes and issues up to two segments.
module msc_merge
    import msc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_side i_side,
    input  t_quo  i_quo [NUM_EDGES],
    output logic  o_valid,
    output t_seg  o_seg
);

    logic [COORD_BITS-1:0] bi_lo, bi_hi, bj_lo, bj_hi;
    logic [COORD_BITS-1:0] pt_i [NUM_EDGES];
    logic [COORD_BITS-1:0] pt_j [NUM_EDGES];
    t_segedges             ed;
    t_seg                  seg0, seg1;
    logic                  r_out_vld, n_out_vld;
    t_seg                  r_out, n_out;
    logic                  r_pend, n_pend;
    t_seg                  r_seg1, n_seg1;

    // Corner coordinates of the cell
    assign bi_lo = COORD_BITS'(i_side.base_i) << FRAC_BITS;
    assign bj_lo = COORD_BITS'(i_side.base_j) << FRAC_BITS;
    assign bi_hi = (COORD_BITS'(i_side.base_i) + COORD_BITS'(1)) << FRAC_BITS;
    assign bj_hi = (COORD_BITS'(i_side.base_j) + COORD_BITS'(1)) << FRAC_BITS;

    // Crossing point on each edge
    always_comb begin
        pt_i[EDGE_TOP]    = bi_lo + COORD_BITS'(i_quo[EDGE_TOP].flo);
        pt_j[EDGE_TOP]    = bj_hi;
        pt_i[EDGE_RIGHT]  = bi_hi;
        pt_j[EDGE_RIGHT]  = bj_hi - COORD_BITS'(i_quo[EDGE_RIGHT].cei);
        pt_i[EDGE_BOTTOM] = bi_hi - COORD_BITS'(i_quo[EDGE_BOTTOM].cei);
        pt_j[EDGE_BOTTOM] = bj_lo;
        pt_i[EDGE_LEFT]   = bi_lo;
        pt_j[EDGE_LEFT]   = bj_lo + COORD_BITS'(i_quo[EDGE_LEFT].flo);
    end

    // Pick segment ends, swap them for a flipped saddle
    always_comb begin
        ed = seg_edges(i_side.tab);
        if (i_side.flip) begin
            seg0 = '{pt_i[ed.s0b], pt_j[ed.s0b], pt_i[ed.s0a], pt_j[ed.s0a],
                     i_side.nseg == 2'd1};
            seg1 = '{pt_i[ed.s1b], pt_j[ed.s1b], pt_i[ed.s1a], pt_j[ed.s1a], 1'b1};
        end else begin
            seg0 = '{pt_i[ed.s0a], pt_j[ed.s0a], pt_i[ed.s0b], pt_j[ed.s0b],
                     i_side.nseg == 2'd1};
            seg1 = '{pt_i[ed.s1a], pt_j[ed.s1a], pt_i[ed.s1b], pt_j[ed.s1b], 1'b1};
        end
    end

    // Issue the first segment, hold the second for the next cycle
    always_comb begin
        n_out_vld = 1'b0;
        n_out     = r_out;
        n_pend    = 1'b0;
        n_seg1    = r_seg1;
        if (i_valid && i_side.nseg != 2'd0) begin
            n_out_vld = 1'b1;
            n_out     = seg0;
            n_pend    = (i_side.nseg == 2'd2);
            n_seg1    = seg1;
        end else if (r_pend) begin
            n_out_vld = 1'b1;
            n_out     = r_seg1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
            r_pend    <= n_pend;
        end
        r_out  <= n_out;
        r_seg1 <= n_seg1;
    end

    assign o_valid = r_out_vld;
    assign o_seg   = r_out;

endmodule

FILE: rtl/core/marching_squares_cell.sv
// Top level of the marching squares cell block: case forming, edge lanes and merge.
//
//  Channel  Signals                       Handshake
//  -------  ----------------------------  ----------------------------------
//  cell     i_cell                        taken on start && !busy
//  segment  o_seg                         o_valid strobe, one cycle each
//  config   i_cfg_we, i_cfg_data          written on i_cfg_we, threshold
//
//  A cell may be taken every second cycle: busy is high for the one cycle
//  after each accepted cell, which leaves room for a second segment.
//  The first segment passes the prep register, which loads at the accepting edge,
//  then FRAC_BITS+1 divider stages per edge lane and one output register; the
//  second, if any, shows in the cycle right after it.
//  Reset clears the threshold to 0 and empties the pipeline.
//  The receiver cannot stall; the block never holds a segment back.
module marching_squares_cell
    import msc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  t_cell                  i_cell,
    input  logic                   i_cfg_we,
    input  logic [SAMPLE_BITS-1:0] i_cfg_data,
    output logic                   o_valid,
    output t_seg                   o_seg
);

    logic signed [SAMPLE_BITS-1:0] r_thr;
    logic                          r_busy;
    logic                          accept;
    logic signed [SAMPLE_BITS-1:0] v [NUM_EDGES];
    logic signed [SAMPLE_BITS+1:0] sum, thr4;
    logic [3:0]                    cs;
    logic                          saddle_flip;
    t_side                         n_side;
    logic [AW-1:0]                 n_un [NUM_EDGES];
    logic [AW-1:0]                 n_ud [NUM_EDGES];
    logic [AW-1:0]                 r_un [NUM_EDGES];
    logic [AW-1:0]                 r_ud [NUM_EDGES];
    t_side                         r_side0;
    logic                          r_v0;
    t_side                         r_side [QW];
    logic [QW-1:0]                 r_vld;
    t_quo                          quo [NUM_EDGES];

    assign accept = start && !r_busy;
    assign busy   = r_busy;

    // Threshold register and the one-cycle gap after each cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= '0;
            r_busy <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            r_busy <= accept;
        end
    end

    // Form the case, resolve the saddle, clamp the base corner
    always_comb begin
        v[0] = i_cell.value_i0_j1;
        v[1] = i_cell.value_i1_j1;
        v[2] = i_cell.value_i1_j0;
        v[3] = i_cell.value_i0_j0;
        cs   = {v[0] > r_thr, v[1] > r_thr, v[2] > r_thr, v[3] > r_thr};
        sum  = (SAMPLE_BITS+2)'(v[0]) + (SAMPLE_BITS+2)'(v[1])
             + (SAMPLE_BITS+2)'(v[2]) + (SAMPLE_BITS+2)'(v[3]);
        thr4 = (SAMPLE_BITS+2)'(r_thr) <<< 2;
        saddle_flip = (cs == 4'd5 || cs == 4'd10) && (sum < thr4);
        n_side.base_i = (i_cell.cell_i > IDX_MAX) ? IDX_MAX : i_cell.cell_i;
        n_side.base_j = (i_cell.cell_j > IDX_MAX) ? IDX_MAX : i_cell.cell_j;
        n_side.tab    = saddle_flip ? ~cs : cs;
        n_side.flip   = saddle_flip;
        n_side.nseg   = seg_count(cs);
    end

    // Distance to the level and span of each edge, as magnitudes
    for (genvar e = 0; e < NUM_EDGES; e++) begin : g_edge
        logic signed [AW-1:0] num, den;
        assign num     = AW'(r_thr) - AW'(v[e]);
        assign den     = AW'(v[(e + 1) % NUM_EDGES]) - AW'(v[e]);
        assign n_un[e] = num[AW-1] ? AW'(-num) : AW'(num);
        assign n_ud[e] = den[AW-1] ? AW'(-den) : AW'(den);
    end

    // Prep stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= accept;
        end
        r_side0 <= n_side;
        r_un    <= n_un;
        r_ud    <= n_ud;
    end

    // Edge lanes
    for (genvar e = 0; e < NUM_EDGES; e++) begin : g_lane
        msc_lane u_lane (
            .i_clk (i_clk),
            .i_un  (r_un[e]),
            .i_ud  (r_ud[e]),
            .o_quo (quo[e])
        );
    end

    // Carry cell info alongside the divider stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[QW-2:0], r_v0};
        end
        r_side[0] <= r_side0;
        for (int k = 1; k < QW; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    msc_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[QW-1]),
        .i_side  (r_side[QW-1]),
        .i_quo   (quo),
        .o_valid (o_valid),
        .o_seg   (o_seg)
    );

endmodule

FILE: rtl/core/msc_checker.sv
// Port-level checks for the marching squares cell block, bound to the top level.
module msc_checker
    import msc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input t_seg o_seg
);

    // Hold off the next cell for one cycle after each accepted cell
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted item");

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    // A segment that is not the last is followed at once by the last one
    a_second_segment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_seg.last_segment) |=> (o_valid && o_seg.last_segment))
        else $error("second segment missing");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !busy))
        else $error("output active after reset");

endmodule

bind marching_squares_cell msc_checker u_msc_checker (.*);

FILE: bench/marching_squares_cell_test.sv
// Testbench for the marching squares cell block: directed and random cells, scoreboard check.
module marching_squares_cell_test;
    timeunit 1ns;
    timeprecision 1ps;
    import msc_pkg::*;

    // Expected segments, kept in order of arrival
    class seg_scoreboard;
        t_seg pending[$];
        int   errors;
        logic signed [SAMPLE_BITS-1:0] level;

        function new();
            errors = 0;
            level  = '0;
        endfunction

        // Point on one cell edge, both coordinates with fraction bits
        function automatic void edge_point(input int e, input longint v[4],
                                           input longint bi, input longint bj,
                                           output logic [COORD_BITS-1:0] pi,
                                           output logic [COORD_BITS-1:0] pj);
            int a, b;
            longint n, d, un, ud, fl, ce, c;
            int off_i[4];
            int off_j[4];
            off_i = '{0, 1, 1, 0};
            off_j = '{1, 1, 0, 0};
            a = e;
            b = (e + 1) % 4;
            n = longint'(level) - v[a];
            d = v[b] - v[a];
            un = n < 0 ? -n : n;
            ud = d < 0 ? -d : d;
            fl = 0;
            ce = 0;
            if (ud != 0) begin
                fl = (un << FRAC_BITS) / ud;
                ce = ((un << FRAC_BITS) + ud - 1) / ud;
            end
            c = (bi + off_i[a]) << FRAC_BITS;
            if (off_i[b] > off_i[a]) c += fl;
            else if (off_i[b] < off_i[a]) c -= ce;
            pi = c[COORD_BITS-1:0];
            c = (bj + off_j[a]) << FRAC_BITS;
            if (off_j[b] > off_j[a]) c += fl;
            else if (off_j[b] < off_j[a]) c -= ce;
            pj = c[COORD_BITS-1:0];
        endfunction

        // Work out the segments of an accepted cell
        function automatic void note_cell(input t_cell cl);
            longint v[4];
            longint bi, bj, sum;
            int cs, tb, nseg;
            bit flip;
            t_segedges ed;
            t_edge ea, eb;
            t_seg sg;
            logic [COORD_BITS-1:0] ai, aj, zi, zj;
            v[0] = cl.value_i0_j1;
            v[1] = cl.value_i1_j1;
            v[2] = cl.value_i1_j0;
            v[3] = cl.value_i0_j0;
            bi = cl.cell_i > IDX_MAX ? IDX_MAX : cl.cell_i;
            bj = cl.cell_j > IDX_MAX ? IDX_MAX : cl.cell_j;
            cs = 0;
            sum = 0;
            for (int k = 0; k < 4; k++) begin
                if (v[k] > longint'(level)) cs += 8 >> k;
                sum += v[k];
            end
            nseg = (cs == 0 || cs == 15) ? 0 : (cs == 5 || cs == 10) ? 2 : 1;
            tb = cs;
            flip = 0;
            if ((cs == 5 || cs == 10) && sum < 4 * longint'(level)) begin
                tb = 15 - cs;
                flip = 1;
            end
            ed = seg_edges(4'(tb));
            for (int s = 0; s < nseg; s++) begin
                ea = s == 0 ? ed.s0a : ed.s1a;
                eb = s == 0 ? ed.s0b : ed.s1b;
                edge_point(int'(ea), v, bi, bj, ai, aj);
                edge_point(int'(eb), v, bi, bj, zi, zj);
                if (flip) sg = '{zi, zj, ai, aj, 1'b0};
                else sg = '{ai, aj, zi, zj, 1'b0};
                sg.last_segment = (s + 1 == nseg);
                pending.push_back(sg);
            end
        endfunction

        // Compare one segment against the oldest expectation
        function automatic void check_seg(input t_seg got);
            t_seg want;
            if (pending.size() == 0) begin
                report_err("segment with none expected");
                return;
            end
            want = pending.pop_front();
            if (got.start_i !== want.start_i) report_err("start_i");
            if (got.start_j !== want.start_j) report_err("start_j");
            if (got.end_i !== want.end_i) report_err("end_i");
            if (got.end_j !== want.end_j) report_err("end_j");
            if (got.last_segment !== want.last_segment) report_err("last_segment");
        endfunction

        function automatic void report_err(input string what);
            errors++;
            $display("mismatch at %0t: %s", $realtime, what);
        endfunction
    endclass

    logic i_clk, i_rst_n, start, busy, i_cfg_we, o_valid;
    t_cell i_cell;
    logic [SAMPLE_BITS-1:0] i_cfg_data;
    t_seg o_seg;
    seg_scoreboard sb;
    bit calm;

    marching_squares_cell u_top (.*);

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("simulation failed");
        $finish;
    end

    // Check every strobed segment
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_seg(o_seg);
    end

    // Drop start, wait for the pipeline to drain, then let it settle
    task automatic drain();
        start <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (FRAC_BITS + 8) @(negedge i_clk);
    endtask

    task automatic set_level(input logic signed [SAMPLE_BITS-1:0] lv);
        drain();
        i_cfg_we   <= 1;
        i_cfg_data <= lv;
        @(negedge i_clk);
        i_cfg_we <= 0;
        sb.level = lv;
    endtask

    // Offer one cell and hold it until taken; start stays high for the next one
    task automatic send_cell(input t_cell cl);
        if (!calm && $urandom_range(0, 3) == 0) begin
            start <= 0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        start  <= 1;
        i_cell <= cl;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
            @(negedge i_clk);
        end
        sb.note_cell(cl);
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_sample(input logic signed [15:0] lv);
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return lv + 16'($urandom_range(0, 64)) - 16'sd32;
            2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return lv + 16'($urandom_range(0, 4000)) - 16'sd2000;
        endcase
    endfunction

    function automatic t_cell rand_cell(input logic signed [15:0] lv);
        t_cell c;
        c.cell_i = $urandom_range(0, 9) == 0 ? 10'($urandom) : 10'($urandom_range(0, 1022));
        c.cell_j = $urandom_range(0, 9) == 0 ? 10'($urandom) : 10'($urandom_range(0, 1022));
        c.value_i0_j1 = rand_sample(lv);
        c.value_i1_j1 = rand_sample(lv);
        c.value_i1_j0 = rand_sample(lv);
        c.value_i0_j0 = rand_sample(lv);
        return c;
    endfunction

    initial begin
        t_cell c;
        logic signed [15:0] levels[5];
        sb = new();
        calm = 0;
        start = 0;
        i_cfg_we = 0;
        i_cfg_data = '0;
        i_cell = '0;
        i_rst_n = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1;

        // Directed: every case at level zero, extreme samples and indexes
        for (int cs = 0; cs < 16; cs++) begin
            c.cell_i = cs[0] ? 10'd1023 : 10'd0;
            c.cell_j = cs[1] ? 10'd1022 : 10'd0;
            c.value_i0_j1 = cs[3] ? 16'sh7fff : 16'sh8000;
            c.value_i1_j1 = cs[2] ? 16'sd5 : -16'sd1;
            c.value_i1_j0 = cs[1] ? 16'sd1 : 16'sd0;
            c.value_i0_j0 = cs[0] ? 16'sd300 : -16'sd7;
            send_cell(c);
        end
        // Saddles on both sides of the corner-sum test
        c = '{10'd5, 10'd9, 16'sd10, -16'sd100, 16'sd10, -16'sd100};
        send_cell(c);
        c = '{10'd5, 10'd9, 16'sd100, -16'sd10, 16'sd100, -16'sd10};
        send_cell(c);
        c = '{10'd7, 10'd2, -16'sd100, 16'sd10, -16'sd100, 16'sd10};
        send_cell(c);
        c = '{10'd7, 10'd2, -16'sd10, 16'sd100, -16'sd10, 16'sd100};
        send_cell(c);

        // Random phases across several iso levels
        levels = '{16'sh8000, 16'sh7fff, 16'sd0, -16'sd1234, 16'sd777};
        for (int p = 0; p < 6; p++) begin
            logic signed [15:0] lv;
            lv = p < 5 ? levels[p] : 16'($urandom);
            set_level(lv);
            if (p == 5) calm = 1;
            for (int n = 0; n < 125; n++) begin
                if (n == 60 && p == 2) drain();
                send_cell(rand_cell(lv));
            end
        end

        drain();
        if (sb.errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule

FILE: marching_squares_cell.f
rtl/core/msc_pkg.sv
rtl/core/msc_lane.sv
rtl/core/msc_merge.sv
rtl/core/marching_squares_cell.sv
rtl/core/msc_checker.sv
bench/marching_squares_cell_test.sv
